FILE: rtl/core/psc_pkg.sv
// psc_pkg: shared types and constants of the pressure sample conditioner
// no dependencies; used by every module under rtl/core except psc_ram

package psc_pkg;

    // field widths
    localparam int COUNT_W = 24;
    localparam int PRESS_W = 21;
    localparam int CFG_W   = 24;
    localparam int IDX_W   = 3;

    // shared divider widths
    localparam int DIV_NW  = 48;
    localparam int DIV_DW  = 24;
    localparam int DIV_CW  = 6;

    // kpa per mmhg in q24
    localparam logic [21:0] KPA_PER_MMHG_Q24 = 22'd2236778;
    localparam logic [7:0]  HITS_MAX         = 8'hFF;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_COUNT_FLOOR   = 3'd0;
    localparam logic [IDX_W-1:0] REG_COUNT_CEILING = 3'd1;
    localparam logic [IDX_W-1:0] REG_PRESS_FLOOR   = 3'd2;
    localparam logic [IDX_W-1:0] REG_PRESS_CEILING = 3'd3;
    localparam logic [IDX_W-1:0] REG_CAL_LENGTH    = 3'd4;
    localparam logic [IDX_W-1:0] REG_NZ_BAND       = 3'd5;
    localparam logic [IDX_W-1:0] REG_NZ_RUN        = 3'd6;
    localparam logic [IDX_W-1:0] REG_TRACK_SHIFT   = 3'd7;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LOAD,
        S_READ,
        S_INS,
        S_MED,
        S_CAL,
        S_CDIV,
        S_CFIN,
        S_CLAMP,
        S_MAP,
        S_MST,
        S_MDIV,
        S_MFIN,
        S_KMUL,
        S_KFIN,
        S_TRACK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic load;
        logic rd_issue;
        logic ins;
        logic med;
        logic cal;
        logic cal_fin;
        logic clamp;
        logic map;
        logic mdiv_start;
        logic mm_fin;
        logic kmul;
        logic kfin;
        logic track;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic sel_ok;
        logic last_slot;
        logic calibrated;
        logic map_direct;
        logic div_busy;
        logic out_free;
    } t_sts;

endpackage

FILE: rtl/core/psc_ram.sv
// psc_ram: generic single-write, single-read ram with registered read data
// no dependencies

module psc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 20,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/psc_div.sv
// psc_div: radix-2 restoring divider, one quotient bit per cycle
// depends on psc_pkg for operand widths

module psc_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [psc_pkg::DIV_NW-1:0] i_num,
    input  logic [psc_pkg::DIV_DW-1:0] i_den,
    output logic                       o_busy,
    output logic [psc_pkg::DIV_NW-1:0] o_quot
);

    logic [psc_pkg::DIV_DW:0]   r_rem;
    logic [psc_pkg::DIV_NW-1:0] r_quot;
    logic [psc_pkg::DIV_DW-1:0] r_den;
    logic [psc_pkg::DIV_CW-1:0] r_cnt;
    logic                       r_busy;

    logic [psc_pkg::DIV_DW:0]   w_rem_sh;
    logic                       w_fit;

    assign w_rem_sh = {r_rem[psc_pkg::DIV_DW-1:0], r_quot[psc_pkg::DIV_NW-1]};
    assign w_fit    = (w_rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == psc_pkg::DIV_CW'(psc_pkg::DIV_NW - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_num;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_rem  <= w_fit ? (w_rem_sh - {1'b0, r_den}) : w_rem_sh;
            r_quot <= {r_quot[psc_pkg::DIV_NW-2:0], w_fit};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

FILE: rtl/core/psc_dp.sv
// psc_dp: datapath with sensor state, sample ring, window sort, mapping and tracking
// depends on psc_pkg, psc_ram and psc_div

module psc_dp #(
    parameter int SENSORS      = 4,
    parameter int WINDOW       = 5,
    parameter int TRACK_ENABLE = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  psc_pkg::t_cmd               i_cmd,
    output psc_pkg::t_sts               o_sts,
    input  logic [1:0]                  i_sensor_index,
    input  logic [psc_pkg::COUNT_W-1:0] i_sample_counts,
    input  logic                        i_cfg_we,
    input  logic [psc_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [psc_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [psc_pkg::COUNT_W-1:0] o_median_counts,
    output logic [psc_pkg::COUNT_W-1:0] o_corrected_counts,
    output logic [psc_pkg::COUNT_W-1:0] o_reference_counts,
    output logic                        o_is_calibrated,
    output logic [psc_pkg::PRESS_W-1:0] o_pressure_mmhg_q8,
    output logic [psc_pkg::PRESS_W-1:0] o_pressure_kpa_q8
);

    localparam int SW    = (SENSORS > 1) ? $clog2(SENSORS) : 1;
    localparam int HW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW    = $clog2(WINDOW + 1);
    localparam int DEPTH = SENSORS * WINDOW;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = psc_pkg::COUNT_W;
    localparam int PR_W  = psc_pkg::PRESS_W;

    function automatic logic [PR_W-1:0] sat21(input logic signed [23:0] v);
        logic [PR_W-1:0] res;
        if (v > 24'sd1048575) begin
            res = 21'h0FFFFF;
        end else if (v < -24'sd1048576) begin
            res = 21'h100000;
        end else begin
            res = v[PR_W-1:0];
        end
        return res;
    endfunction

    // configuration
    logic [CNT_W-1:0] r_count_floor;
    logic [CNT_W-1:0] r_count_ceiling;
    logic [PR_W-1:0]  r_press_floor;
    logic [PR_W-1:0]  r_press_ceiling;
    logic [7:0]       r_cal_length;
    logic [19:0]      r_nz_band;
    logic [7:0]       r_nz_run;
    logic [3:0]       r_track_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_floor   <= 24'd1677722;
            r_count_ceiling <= 24'd15099494;
            r_press_floor   <= 21'd0;
            r_press_ceiling <= 21'd330990;
            r_cal_length    <= 8'd16;
            r_nz_band       <= 20'd256;
            r_nz_run        <= 8'd10;
            r_track_shift   <= 4'd4;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                psc_pkg::REG_COUNT_FLOOR:   r_count_floor   <= i_cfg_data;
                psc_pkg::REG_COUNT_CEILING: r_count_ceiling <= i_cfg_data;
                psc_pkg::REG_PRESS_FLOOR:   r_press_floor   <= i_cfg_data[PR_W-1:0];
                psc_pkg::REG_PRESS_CEILING: r_press_ceiling <= i_cfg_data[PR_W-1:0];
                psc_pkg::REG_CAL_LENGTH:    r_cal_length    <= i_cfg_data[7:0];
                psc_pkg::REG_NZ_BAND:       r_nz_band       <= i_cfg_data[19:0];
                psc_pkg::REG_NZ_RUN:        r_nz_run        <= i_cfg_data[7:0];
                psc_pkg::REG_TRACK_SHIFT:   r_track_shift   <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // per-sensor state
    logic [HW-1:0]    r_head  [SENSORS];
    logic [31:0]      r_csum  [SENSORS];
    logic [7:0]       r_ccnt  [SENSORS];
    logic             r_cflag [SENSORS];
    logic [CNT_W-1:0] r_zref  [SENSORS];
    logic [7:0]       r_hits  [SENSORS];

    // item registers
    logic [SW-1:0]    r_sel;
    logic             r_sel_ok;
    logic [CNT_W-1:0] r_sample;
    logic [CW-1:0]    r_n;
    logic [CW-1:0]    r_rd_cnt;
    logic [CW-1:0]    r_srt_cnt;
    logic [CNT_W-1:0] r_sorted [WINDOW];
    logic [CNT_W-1:0] r_med;
    logic [CNT_W-1:0] r_corr;
    logic [PR_W-1:0]  r_mm;
    logic [PR_W-1:0]  r_kpa;
    logic [45:0]      r_prod;
    logic             r_prod_neg;
    logic [42:0]      r_kprod;
    logic             r_kneg;

    // ring write and read addressing
    logic [HW-1:0]    w_head;
    logic [HW-1:0]    w_head_nx;
    logic [AW-1:0]    w_waddr;
    logic [AW-1:0]    w_raddr;
    logic [CNT_W-1:0] w_rdata;

    assign w_head    = (int'(r_head[r_sel]) >= WINDOW) ? '0 : r_head[r_sel];
    assign w_head_nx = (int'(w_head) + 1 >= WINDOW) ? '0 : HW'(int'(w_head) + 1);
    assign w_waddr   = AW'(int'(r_sel) * WINDOW + int'(w_head));
    assign w_raddr   = AW'(int'(r_sel) * WINDOW + int'(r_rd_cnt));

    psc_ram #(
        .WIDTH(CNT_W),
        .DEPTH(DEPTH)
    ) u_ring (
        .i_clk  (i_clk),
        .i_we   (i_cmd.load),
        .i_waddr(w_waddr),
        .i_wdata(r_sample),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // insertion of one ring beat into the sorted window
    logic             w_gt     [WINDOW];
    logic [CNT_W-1:0] w_sorted [WINDOW];

    always_comb begin
        for (int k = 0; k < WINDOW; k++) begin
            w_gt[k] = (k >= int'(r_srt_cnt)) || (r_sorted[k] > w_rdata);
        end
        for (int k = 0; k < WINDOW; k++) begin
            if (!w_gt[k]) begin
                w_sorted[k] = r_sorted[k];
            end else if (k == 0) begin
                w_sorted[k] = w_rdata;
            end else if (!w_gt[k-1]) begin
                w_sorted[k] = w_rdata;
            end else begin
                w_sorted[k] = r_sorted[k-1];
            end
        end
    end

    // shared divider
    logic                       w_div_start;
    logic [psc_pkg::DIV_NW-1:0] w_div_num;
    logic [psc_pkg::DIV_DW-1:0] w_div_den;
    logic                       w_div_busy;
    logic [psc_pkg::DIV_NW-1:0] w_div_quot;

    logic [31:0] w_csum_nx;
    logic [7:0]  w_ccnt_nx;

    assign w_csum_nx = r_csum[r_sel] + 32'(r_med);
    assign w_ccnt_nx = (r_ccnt[r_sel] < r_cal_length) ? r_ccnt[r_sel] + 8'd1 : r_ccnt[r_sel];

    always_comb begin
        if (i_cmd.cal) begin
            w_div_num = psc_pkg::DIV_NW'(w_csum_nx);
            w_div_den = (w_ccnt_nx == 8'd0) ? psc_pkg::DIV_DW'(1) : psc_pkg::DIV_DW'(w_ccnt_nx);
        end else begin
            w_div_num = psc_pkg::DIV_NW'(r_prod);
            w_div_den = r_count_ceiling - r_count_floor;
        end
    end

    assign w_div_start = i_cmd.cal | i_cmd.mdiv_start;

    psc_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_start),
        .i_num  (w_div_num),
        .i_den  (w_div_den),
        .o_busy (w_div_busy),
        .o_quot (w_div_quot)
    );

    // compensation and clamp
    logic signed [25:0] w_comp;
    logic [CNT_W-1:0]   w_corr;

    assign w_comp = $signed({2'b00, r_med}) - $signed({2'b00, r_zref[r_sel]})
                  + $signed({2'b00, r_count_floor});

    always_comb begin
        if (w_comp <= $signed({2'b00, r_count_floor})) begin
            w_corr = r_count_floor;
        end else if (w_comp >= $signed({2'b00, r_count_ceiling})) begin
            w_corr = r_count_ceiling;
        end else begin
            w_corr = w_comp[CNT_W-1:0];
        end
    end

    // linear map to mmhg
    logic               w_map_direct;
    logic signed [21:0] w_dp;
    logic [21:0]        w_dp_mag;
    logic signed [23:0] w_q_s;
    logic signed [23:0] w_mm_sum;

    assign w_map_direct = (r_corr <= r_count_floor) || (r_corr >= r_count_ceiling);
    assign w_dp     = $signed({r_press_ceiling[PR_W-1], r_press_ceiling})
                    - $signed({r_press_floor[PR_W-1], r_press_floor});
    assign w_dp_mag = w_dp[21] ? 22'(-w_dp) : 22'(w_dp);
    assign w_q_s    = r_prod_neg ? -$signed({1'b0, w_div_quot[22:0]})
                                 : $signed({1'b0, w_div_quot[22:0]});
    assign w_mm_sum = $signed({{3{r_press_floor[PR_W-1]}}, r_press_floor}) + w_q_s;

    // kpa conversion, rounded half away from zero
    logic [PR_W-1:0]    w_mm_mag;
    logic [43:0]        w_kround;
    logic signed [23:0] w_kpa_s;

    assign w_mm_mag = r_mm[PR_W-1] ? PR_W'(-r_mm) : r_mm;
    assign w_kround = {1'b0, r_kprod} + 44'h00000800000;
    assign w_kpa_s  = r_kneg ? -$signed({4'b0, w_kround[43:24]})
                             : $signed({4'b0, w_kround[43:24]});

    // zero reference tracking
    logic        w_near;
    logic [7:0]  w_hits_nx;
    logic [40:0] w_tr_r;
    logic [40:0] w_tr_sum;
    logic [40:0] w_tr_v;

    assign w_near    = (w_mm_mag <= {1'b0, r_nz_band});
    assign w_hits_nx = (r_hits[r_sel] < psc_pkg::HITS_MAX) ? r_hits[r_sel] + 8'd1
                                                           : r_hits[r_sel];
    assign w_tr_r    = 41'(r_zref[r_sel]);
    assign w_tr_sum  = (w_tr_r << r_track_shift) - w_tr_r + 41'(r_med);
    assign w_tr_v    = w_tr_sum >> r_track_shift;

    // per-sensor state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SENSORS; s++) begin
                r_head[s]  <= '0;
                r_csum[s]  <= '0;
                r_ccnt[s]  <= '0;
                r_cflag[s] <= 1'b0;
                r_zref[s]  <= '0;
                r_hits[s]  <= '0;
            end
        end else begin
            if (i_cmd.load) begin
                r_head[r_sel] <= w_head_nx;
            end
            if (i_cmd.cal) begin
                r_csum[r_sel] <= w_csum_nx;
                r_ccnt[r_sel] <= w_ccnt_nx;
            end
            if (i_cmd.cal_fin) begin
                r_zref[r_sel] <= (|w_div_quot[psc_pkg::DIV_NW-1:CNT_W]) ? '1
                                                                       : w_div_quot[CNT_W-1:0];
                if (r_ccnt[r_sel] >= r_cal_length) begin
                    r_cflag[r_sel] <= 1'b1;
                end
            end
            if (i_cmd.track && TRACK_ENABLE != 0) begin
                if (w_near) begin
                    r_hits[r_sel] <= w_hits_nx;
                    if (w_hits_nx >= r_nz_run) begin
                        r_zref[r_sel] <= w_tr_v[CNT_W-1:0];
                    end
                end else begin
                    r_hits[r_sel] <= '0;
                end
            end
        end
    end

    // item registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sel    <= SW'(i_sensor_index);
            r_sel_ok <= (32'(i_sensor_index) < SENSORS);
            r_sample <= i_sample_counts;
        end
        if (i_cmd.load) begin
            r_n       <= (32'(r_ccnt[r_sel]) < WINDOW) ? CW'(r_ccnt[r_sel] + 8'd1) : CW'(WINDOW);
            r_rd_cnt  <= '0;
            r_srt_cnt <= '0;
        end
        if (i_cmd.rd_issue) begin
            r_rd_cnt <= r_rd_cnt + 1'b1;
        end
        if (i_cmd.ins) begin
            r_sorted  <= w_sorted;
            r_srt_cnt <= r_srt_cnt + 1'b1;
        end
        if (i_cmd.med) begin
            r_med <= r_sorted[HW'(r_n >> 1)];
        end
        if (i_cmd.cal_fin) begin
            r_corr <= r_med;
            r_mm   <= '0;
            r_kpa  <= '0;
        end
        if (i_cmd.clamp) begin
            r_corr <= w_corr;
        end
        if (i_cmd.map) begin
            if (r_corr <= r_count_floor) begin
                r_mm <= r_press_floor;
            end else if (r_corr >= r_count_ceiling) begin
                r_mm <= r_press_ceiling;
            end
            r_prod     <= 46'(r_corr - r_count_floor) * 46'(w_dp_mag);
            r_prod_neg <= w_dp[21];
        end
        if (i_cmd.mm_fin) begin
            r_mm <= sat21(w_mm_sum);
        end
        if (i_cmd.kmul) begin
            r_kprod <= 43'(w_mm_mag) * 43'(psc_pkg::KPA_PER_MMHG_Q24);
            r_kneg  <= r_mm[PR_W-1];
        end
        if (i_cmd.kfin) begin
            r_kpa <= sat21(w_kpa_s);
        end
    end

    // output register
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (r_sel_ok) begin
                o_median_counts    <= r_med;
                o_corrected_counts <= r_corr;
                o_reference_counts <= r_zref[r_sel];
                o_is_calibrated    <= r_cflag[r_sel];
                o_pressure_mmhg_q8 <= r_mm;
                o_pressure_kpa_q8  <= r_kpa;
            end else begin
                o_median_counts    <= '0;
                o_corrected_counts <= '0;
                o_reference_counts <= '0;
                o_is_calibrated    <= 1'b0;
                o_pressure_mmhg_q8 <= '0;
                o_pressure_kpa_q8  <= '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

    assign o_sts.sel_ok     = r_sel_ok;
    assign o_sts.last_slot  = (CW'(r_srt_cnt + 1'b1) == r_n);
    assign o_sts.calibrated = r_cflag[r_sel];
    assign o_sts.map_direct = w_map_direct;
    assign o_sts.div_busy   = w_div_busy;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

endmodule

FILE: rtl/core/psc_ctrl.sv
// psc_ctrl: sequencer that steps one sample through the datapath
// depends on psc_pkg

module psc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  psc_pkg::t_sts i_sts,
    output psc_pkg::t_cmd o_cmd
);

    psc_pkg::t_state r_state;
    psc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= psc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            psc_pkg::S_IDLE:  if (i_in_valid) n_state = psc_pkg::S_LOAD;
            psc_pkg::S_LOAD:  n_state = i_sts.sel_ok ? psc_pkg::S_READ : psc_pkg::S_DONE;
            psc_pkg::S_READ:  n_state = psc_pkg::S_INS;
            psc_pkg::S_INS:   n_state = i_sts.last_slot ? psc_pkg::S_MED : psc_pkg::S_READ;
            psc_pkg::S_MED:   n_state = i_sts.calibrated ? psc_pkg::S_CLAMP : psc_pkg::S_CAL;
            psc_pkg::S_CAL:   n_state = psc_pkg::S_CDIV;
            psc_pkg::S_CDIV:  if (!i_sts.div_busy) n_state = psc_pkg::S_CFIN;
            psc_pkg::S_CFIN:  n_state = psc_pkg::S_DONE;
            psc_pkg::S_CLAMP: n_state = psc_pkg::S_MAP;
            psc_pkg::S_MAP:   n_state = i_sts.map_direct ? psc_pkg::S_KMUL : psc_pkg::S_MST;
            psc_pkg::S_MST:   n_state = psc_pkg::S_MDIV;
            psc_pkg::S_MDIV:  if (!i_sts.div_busy) n_state = psc_pkg::S_MFIN;
            psc_pkg::S_MFIN:  n_state = psc_pkg::S_KMUL;
            psc_pkg::S_KMUL:  n_state = psc_pkg::S_KFIN;
            psc_pkg::S_KFIN:  n_state = psc_pkg::S_TRACK;
            psc_pkg::S_TRACK: n_state = psc_pkg::S_DONE;
            psc_pkg::S_DONE:  if (i_sts.out_free) n_state = psc_pkg::S_IDLE;
            default:          n_state = psc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.accept     = (r_state == psc_pkg::S_IDLE) && i_in_valid;
        o_cmd.load       = (r_state == psc_pkg::S_LOAD) && i_sts.sel_ok;
        o_cmd.rd_issue   = (r_state == psc_pkg::S_READ);
        o_cmd.ins        = (r_state == psc_pkg::S_INS);
        o_cmd.med        = (r_state == psc_pkg::S_MED);
        o_cmd.cal        = (r_state == psc_pkg::S_CAL);
        o_cmd.cal_fin    = (r_state == psc_pkg::S_CFIN);
        o_cmd.clamp      = (r_state == psc_pkg::S_CLAMP);
        o_cmd.map        = (r_state == psc_pkg::S_MAP);
        o_cmd.mdiv_start = (r_state == psc_pkg::S_MST);
        o_cmd.mm_fin     = (r_state == psc_pkg::S_MFIN);
        o_cmd.kmul       = (r_state == psc_pkg::S_KMUL);
        o_cmd.kfin       = (r_state == psc_pkg::S_KFIN);
        o_cmd.track      = (r_state == psc_pkg::S_TRACK);
        o_cmd.out_load   = (r_state == psc_pkg::S_DONE) && i_sts.out_free;
    end

    assign o_in_ready = (r_state == psc_pkg::S_IDLE);

endmodule

FILE: rtl/core/pressure_sample_conditioner.sv
// pressure_sample_conditioner: median filter with auto-zero tracking, per sensor
// sequence per accepted beat: ring write, then a read state and an insert state per slot
// (n <= WINDOW slots), median pick, then either the calibration divide on the 48-step
// shared radix-2 divider, or clamp, map (direct or through that divider), kpa and tracking
// one sample at a time: the next beat is taken only once the result is in the output
// register, which may still be waiting on the master side
// reset: synchronous active low; clears sensor state, config to defaults, no ring clear

module pressure_sample_conditioner #(
    parameter int SENSORS      = 4,
    parameter int WINDOW       = 5,
    parameter int TRACK_ENABLE = 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // [1:0] sensor_index, [25:2] sample_counts
    input  logic [31:0]               i_s_axis_tdata,
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    // [23:0] median_counts, [47:24] corrected_counts, [71:48] reference_counts,
    // [92:72] pressure_mmhg_q8, [113:93] pressure_kpa_q8
    output logic [119:0]              o_m_axis_tdata,
    // [0] is_calibrated
    output logic                      o_m_axis_tuser,
    input  logic                      i_cfg_we,
    input  logic [psc_pkg::IDX_W-1:0] i_cfg_index,
    input  logic [psc_pkg::CFG_W-1:0] i_cfg_data
);

    psc_pkg::t_cmd w_cmd;
    psc_pkg::t_sts w_sts;

    logic [psc_pkg::COUNT_W-1:0] w_med;
    logic [psc_pkg::COUNT_W-1:0] w_corr;
    logic [psc_pkg::COUNT_W-1:0] w_ref;
    logic [psc_pkg::PRESS_W-1:0] w_mm;
    logic [psc_pkg::PRESS_W-1:0] w_kpa;

    psc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_s_axis_tvalid),
        .o_in_ready(o_s_axis_tready),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd)
    );

    psc_dp #(
        .SENSORS     (SENSORS),
        .WINDOW      (WINDOW),
        .TRACK_ENABLE(TRACK_ENABLE)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_sensor_index    (i_s_axis_tdata[1:0]),
        .i_sample_counts   (i_s_axis_tdata[25:2]),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_out_ready       (i_m_axis_tready),
        .o_out_valid       (o_m_axis_tvalid),
        .o_median_counts   (w_med),
        .o_corrected_counts(w_corr),
        .o_reference_counts(w_ref),
        .o_is_calibrated   (o_m_axis_tuser),
        .o_pressure_mmhg_q8(w_mm),
        .o_pressure_kpa_q8 (w_kpa)
    );

    assign o_m_axis_tdata = {6'b0, w_kpa, w_mm, w_ref, w_corr, w_med};

    // a taken beat parks the sequencer until the result is produced
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input taken while a sample is in flight");

    // an uncalibrated sensor reports zero pressure
    a_uncal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |->
        (o_m_axis_tdata[92:72] == '0 && o_m_axis_tdata[113:93] == '0))
        else $error("nonzero pressure before calibration");

    // a new result is only loaded once the previous one has been taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> $stable(o_m_axis_tdata))
        else $error("pending result overwritten");

endmodule
